>>> src/gpu_command_decode_and_state_core_defines.svh
// Assertion macros shared by the command decode and state core.
`ifndef GPU_COMMAND_DECODE_AND_STATE_CORE_DEFINES_SVH
`define GPU_COMMAND_DECODE_AND_STATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside of reset.
`define GCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition implies another on the same clock edge.
`define GCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define GCD_ASSERT(lbl, prop, msg)
`define GCD_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

>>> src/gcd_pkg.sv
// Types, command codes and constants of the command decode and state core.
`default_nettype none
package gcd_pkg;

    // Command kinds reported with each result.
    typedef enum logic [4:0] {
        K_UNKNOWN    = 5'd0,
        K_NOP        = 5'd1,
        K_FILL       = 5'd2,
        K_IRQ        = 5'd3,
        K_TRI        = 5'd4,
        K_QUAD       = 5'd5,
        K_LINE       = 5'd6,
        K_POLYLINE   = 5'd7,
        K_SPRITE     = 5'd8,
        K_COPY       = 5'd9,
        K_TO_VRAM    = 5'd10,
        K_FROM_VRAM  = 5'd11,
        K_DRAW_MODE  = 5'd12,
        K_TEX_WINDOW = 5'd13,
        K_AREA_TL    = 5'd14,
        K_AREA_BR    = 5'd15,
        K_OFFSET     = 5'd16,
        K_MASK       = 5'd17,
        K_RESET      = 5'd18,
        K_RESET_BUF  = 5'd19,
        K_IRQ_ACK    = 5'd20,
        K_DISP_EN    = 5'd21,
        K_DMA        = 5'd22,
        K_START      = 5'd23,
        K_HRANGE     = 5'd24,
        K_VRANGE     = 5'd25,
        K_DISP_MODE  = 5'd26
    } kind_t;

    // Screen geometry selected by the display mode byte.
    localparam logic [9:0] WIDTH_256  = 10'd256;
    localparam logic [9:0] WIDTH_320  = 10'd320;
    localparam logic [9:0] WIDTH_368  = 10'd368;
    localparam logic [9:0] WIDTH_512  = 10'd512;
    localparam logic [9:0] WIDTH_640  = 10'd640;
    localparam logic [8:0] HEIGHT_240 = 9'd240;
    localparam logic [8:0] HEIGHT_480 = 9'd480;

    // A sprite carries its palette in the third word.
    localparam logic [3:0] SPRITE_PALETTE_WORDS = 4'd3;
    localparam logic [3:0] GP1_LENGTH           = 4'd1;

    // One assembled command.
    typedef struct packed {
        logic        from_gp1;
        logic [7:0]  opcode;
        logic [3:0]  word_count;
        logic [31:0] first_word;
        logic [31:0] third_word;
    } cmd_t;

    // One result: kind, length and the register file after the update.
    typedef struct packed {
        logic [4:0]  command_kind;
        logic [3:0]  expected_words;
        logic [28:0] draw_state;
        logic [15:0] area_top_left;
        logic [15:0] area_bottom_right;
        logic [15:0] draw_offset;
        logic [29:0] display_state;
        logic [18:0] display_start;
        logic [23:0] horizontal_range;
        logic [19:0] vertical_range;
    } rsp_t;

    // Decoder output passed to the register file.
    typedef struct packed {
        kind_t      kind;
        logic [3:0] length;
    } decode_t;

    // Drawing and display register file.
    typedef struct packed {
        logic [10:0] draw_mode_bits;
        logic [14:0] sprite_palette;
        logic [15:0] area_top_left;
        logic [15:0] area_bottom_right;
        logic [15:0] draw_offset;
        logic [1:0]  mask_setting;
        logic        irq_flag;
        logic        display_on;
        logic [7:0]  display_mode_bits;
        logic [9:0]  screen_width;
        logic [8:0]  screen_height;
        logic [1:0]  dma_dir;
        logic [9:0]  vram_x_start;
        logic [8:0]  vram_y_start;
        logic [11:0] h_range_start;
        logic [11:0] h_range_end;
        logic [9:0]  v_range_start;
        logic [9:0]  v_range_end;
    } regs_t;

endpackage
`default_nettype wire

>>> src/gcd_decoder.sv
// Opcode decoder: command kind and expected packet length.
`default_nettype none
module gcd_decoder (
    input  wire logic            from_gp1,
    input  wire logic [7:0]      opcode,
    output gcd_pkg::decode_t     decode
);
    import gcd_pkg::*;

    kind_t      gp0_kind;
    kind_t      gp1_kind;
    logic [3:0] gp0_length;

    // Drawing port command kinds by opcode range.
    always_comb
    begin
        unique case (opcode) inside
            8'h00, 8'h01:               gp0_kind = K_NOP;
            8'h02:                      gp0_kind = K_FILL;
            8'h1F:                      gp0_kind = K_IRQ;
            [8'h20:8'h27], [8'h30:8'h37]: gp0_kind = K_TRI;
            [8'h28:8'h2F], [8'h38:8'h3F]: gp0_kind = K_QUAD;
            [8'h40:8'h57]:              gp0_kind = K_LINE;
            [8'h58:8'h5F]:              gp0_kind = K_POLYLINE;
            [8'h60:8'h7F]:              gp0_kind = K_SPRITE;
            8'h80:                      gp0_kind = K_COPY;
            8'hA0:                      gp0_kind = K_TO_VRAM;
            8'hC0:                      gp0_kind = K_FROM_VRAM;
            8'hE1:                      gp0_kind = K_DRAW_MODE;
            8'hE2:                      gp0_kind = K_TEX_WINDOW;
            8'hE3:                      gp0_kind = K_AREA_TL;
            8'hE4:                      gp0_kind = K_AREA_BR;
            8'hE5:                      gp0_kind = K_OFFSET;
            8'hE6:                      gp0_kind = K_MASK;
            default:                    gp0_kind = K_UNKNOWN;
        endcase
    end

    // Display port command kinds.
    always_comb
    begin
        unique case (opcode)
            8'h00:   gp1_kind = K_RESET;
            8'h01:   gp1_kind = K_RESET_BUF;
            8'h02:   gp1_kind = K_IRQ_ACK;
            8'h03:   gp1_kind = K_DISP_EN;
            8'h04:   gp1_kind = K_DMA;
            8'h05:   gp1_kind = K_START;
            8'h06:   gp1_kind = K_HRANGE;
            8'h07:   gp1_kind = K_VRANGE;
            8'h08:   gp1_kind = K_DISP_MODE;
            default: gp1_kind = K_UNKNOWN;
        endcase
    end

    // Drawing port packet length in words; unlisted opcodes take one word.
    always_comb
    begin
        unique case (opcode) inside
            8'h02:                                     gp0_length = 4'd3;
            [8'h20:8'h23]:                             gp0_length = 4'd4;
            [8'h24:8'h27]:                             gp0_length = 4'd7;
            [8'h30:8'h33]:                             gp0_length = 4'd6;
            [8'h34:8'h37]:                             gp0_length = 4'd9;
            [8'h28:8'h2B]:                             gp0_length = 4'd5;
            [8'h2C:8'h2F]:                             gp0_length = 4'd9;
            [8'h38:8'h3B]:                             gp0_length = 4'd8;
            [8'h3C:8'h3F]:                             gp0_length = 4'd12;
            [8'h40:8'h47]:                             gp0_length = 4'd3;
            [8'h50:8'h57]:                             gp0_length = 4'd4;
            [8'h64:8'h67]:                             gp0_length = 4'd4;
            [8'h68:8'h6B], [8'h70:8'h73], [8'h78:8'h7B]: gp0_length = 4'd2;
            [8'h60:8'h63], [8'h6C:8'h6F],
            [8'h74:8'h77], [8'h7C:8'h7F]:              gp0_length = 4'd3;
            8'hA0, 8'hC0:                              gp0_length = 4'd3;
            8'h80:                                     gp0_length = 4'd4;
            default:                                   gp0_length = 4'd1;
        endcase
    end

    // Select by port.
    assign decode.kind   = from_gp1 ? gp1_kind : gp0_kind;
    assign decode.length = from_gp1 ? GP1_LENGTH : gp0_length;

endmodule
`default_nettype wire

>>> src/gcd_regfile.sv
// Drawing and display register file with per-command update logic.
`default_nettype none
module gcd_regfile (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire gcd_pkg::kind_t   kind,
    input  wire gcd_pkg::cmd_t    cmd,
    output gcd_pkg::regs_t        regs_next
);
    import gcd_pkg::*;

    regs_t      regs_reg;
    logic       has_words;
    logic [9:0] mode_width;
    logic [8:0] mode_height;

    assign has_words = (cmd.word_count != 4'd0);

    // Screen size from the display mode byte.
    always_comb
    begin
        if (cmd.first_word[6])
        begin
            mode_width = WIDTH_368;
        end
        else
        begin
            case (cmd.first_word[1:0])
                2'd0:    mode_width = WIDTH_256;
                2'd1:    mode_width = WIDTH_320;
                2'd2:    mode_width = WIDTH_512;
                default: mode_width = WIDTH_640;
            endcase
        end
        mode_height = (cmd.first_word[5] && cmd.first_word[2]) ? HEIGHT_480 : HEIGHT_240;
    end

    // Register effect of the command; commands that read the first word
    // need at least one word present.
    always_comb
    begin
        regs_next = regs_reg;
        if (load)
        begin
            unique case (kind)
                K_DRAW_MODE:
                    if (has_words) regs_next.draw_mode_bits = cmd.first_word[10:0];
                K_SPRITE:
                    if (cmd.word_count >= SPRITE_PALETTE_WORDS && cmd.opcode[2])
                        regs_next.sprite_palette = cmd.third_word[30:16];
                K_AREA_TL:
                    if (has_words) regs_next.area_top_left = cmd.first_word[15:0];
                K_AREA_BR:
                    if (has_words) regs_next.area_bottom_right = cmd.first_word[15:0];
                K_OFFSET:
                    if (has_words) regs_next.draw_offset = cmd.first_word[15:0];
                K_MASK:
                    if (has_words) regs_next.mask_setting = cmd.first_word[1:0];
                K_IRQ:
                    regs_next.irq_flag = 1'b1;
                K_IRQ_ACK:
                    regs_next.irq_flag = 1'b0;
                K_DISP_EN:
                    if (has_words) regs_next.display_on = ~cmd.first_word[0];
                K_DISP_MODE:
                    if (has_words)
                    begin
                        regs_next.display_mode_bits = cmd.first_word[7:0];
                        regs_next.screen_width      = mode_width;
                        regs_next.screen_height     = mode_height;
                    end
                K_DMA:
                    if (has_words) regs_next.dma_dir = cmd.first_word[1:0];
                K_START:
                    if (has_words)
                    begin
                        // The x start is always even.
                        regs_next.vram_x_start = {cmd.first_word[9:1], 1'b0};
                        regs_next.vram_y_start = cmd.first_word[18:10];
                    end
                K_HRANGE:
                    if (has_words)
                    begin
                        regs_next.h_range_start = cmd.first_word[11:0];
                        regs_next.h_range_end   = cmd.first_word[23:12];
                    end
                K_VRANGE:
                    if (has_words)
                    begin
                        regs_next.v_range_start = cmd.first_word[9:0];
                        regs_next.v_range_end   = cmd.first_word[19:10];
                    end
                K_RESET:
                    regs_next = '0;
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
`default_nettype wire

>>> src/gpu_command_decode_and_state_core.sv
// Path: a command's input transfer loads the input register; the result register then
// takes its result once that register is free or drains.
// Throughput: one command per cycle unless rsp_ready stalls the result register; decode
// and register update sit between the input register and the result register.
// Reset: rst_n clears the pipeline valid bits and the whole register file to zero.
// A display port reset command also clears the register file.
`default_nettype none
`include "gpu_command_decode_and_state_core_defines.svh"
module gpu_command_decode_and_state_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire gcd_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output gcd_pkg::rsp_t      rsp
);
    import gcd_pkg::*;

    logic    s1_valid_reg;
    cmd_t    s1_cmd_reg;
    logic    s1_advance;
    logic    rsp_valid_reg;
    rsp_t    rsp_reg;
    decode_t decode;
    regs_t   regs_next;
    rsp_t    rsp_next;

    // The input stage moves on when the result register is free or drains.
    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready  = !s1_valid_reg || s1_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_cmd_reg <= cmd;
        end
    end

    gcd_decoder u_decoder (
        .from_gp1 (s1_cmd_reg.from_gp1),
        .opcode   (s1_cmd_reg.opcode),
        .decode   (decode)
    );

    gcd_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_advance),
        .kind      (decode.kind),
        .cmd       (s1_cmd_reg),
        .regs_next (regs_next)
    );

    // Pack the updated register file into the result.
    always_comb
    begin
        rsp_next.command_kind      = decode.kind;
        rsp_next.expected_words    = decode.length;
        rsp_next.draw_state        = {regs_next.irq_flag, regs_next.mask_setting,
                                      regs_next.sprite_palette, regs_next.draw_mode_bits};
        rsp_next.area_top_left     = regs_next.area_top_left;
        rsp_next.area_bottom_right = regs_next.area_bottom_right;
        rsp_next.draw_offset       = regs_next.draw_offset;
        rsp_next.display_state     = {regs_next.dma_dir, regs_next.screen_height,
                                      regs_next.screen_width, regs_next.display_mode_bits,
                                      regs_next.display_on};
        rsp_next.display_start     = {regs_next.vram_y_start, regs_next.vram_x_start};
        rsp_next.horizontal_range  = {regs_next.h_range_end, regs_next.h_range_start};
        rsp_next.vertical_range    = {regs_next.v_range_end, regs_next.v_range_start};
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || rsp_ready)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Display port commands always report a one-word packet.
    `GCD_ASSERT_IMPLY(a_gp1_length, rsp_valid_reg && rsp_reg.command_kind >= K_RESET,
        rsp_reg.expected_words == GP1_LENGTH, "display port command with length other than one")
    // A display port reset leaves every register at zero.
    `GCD_ASSERT_IMPLY(a_reset_clears, rsp_valid_reg && rsp_reg.command_kind == K_RESET,
        rsp_reg.draw_state == '0 && rsp_reg.display_state == '0 && rsp_reg.display_start == '0,
        "register file not cleared by reset command")
    // Interrupt set and acknowledge show in the pending bit of the same result.
    `GCD_ASSERT_IMPLY(a_irq_set, rsp_valid_reg && rsp_reg.command_kind == K_IRQ,
        rsp_reg.draw_state[28], "interrupt not pending after set")
    `GCD_ASSERT_IMPLY(a_irq_ack, rsp_valid_reg && rsp_reg.command_kind == K_IRQ_ACK,
        !rsp_reg.draw_state[28], "interrupt still pending after acknowledge")
    // A held input stage always has a command to hold.
    `GCD_ASSERT(a_ready_when_empty, s1_valid_reg || cmd_ready, "input blocked while stage empty")

endmodule
`default_nettype wire
